>>> rtl/ssrf_pkg.sv
// sonar spike rejection filter: shared widths, register codes and reset values
// no dependencies
`timescale 1ns / 1ps

package ssrf_pkg;

  localparam int RANGE_W          = 16;
  localparam int TIME_W           = 32;
  localparam int CFG_W            = 16;
  localparam int CFG_INDEX_W      = 2;
  localparam int IN_TDATA_W       = 48;
  localparam int IN_TUSER_W       = 1;
  localparam int OUT_TDATA_W      = 8;
  localparam int WINDOW_DEPTH_DEF = 8;
  localparam int SPEED_SCALE      = 1000;
  localparam int SPEED_SCALE_W    = 10;
  localparam int SCALED_DIFF_W    = RANGE_W + SPEED_SCALE_W;
  localparam int PRODUCT_W        = CFG_W + TIME_W;

  localparam logic [CFG_W-1:0] RANGE_MIN_RST   = CFG_W'(301);
  localparam logic [CFG_W-1:0] RANGE_MAX_RST   = CFG_W'(2600);
  localparam logic [CFG_W-1:0] MEAN_LIMIT_RST  = CFG_W'(400);
  localparam logic [CFG_W-1:0] SPEED_LIMIT_RST = CFG_W'(3000);

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_RANGE_MIN   = 2'd0,
    CFG_RANGE_MAX   = 2'd1,
    CFG_MEAN_LIMIT  = 2'd2,
    CFG_SPEED_LIMIT = 2'd3
  } cfg_reg_t;

  typedef enum logic [IN_TUSER_W-1:0] {
    OP_TIME_BASE = 1'b0,
    OP_MEASURE   = 1'b1
  } op_t;

  typedef struct packed {
    logic range_pass;
    logic mean_pass;
    logic speed_pass;
  } ssrf_verdict_t;

endpackage

>>> rtl/sonar_spike_rejection_filter_unit.sv
// sonar spike rejection filter top level: config registers, two-stage pipe,
// window memory and output register; depends on ssrf_pkg, ssrf_window_mem, ssrf_check
`timescale 1ns / 1ps

//  channel   dir  handshake            payload
//  s_        in   s_tvalid/s_tready    tdata {range_mm, timestamp_ms}, tuser operation
//  m_        out  m_tvalid/m_tready    tdata sample_ok in bit 0
//  cfg_      in   cfg_valid/cfg_ready  cfg_index, cfg_data
//
//  one item per cycle sustained unless the output stalls; a measurement's verdict is
//  offered from the output register (input stage loads at the accepting edge, the check
//  against the window sum and memory read word loads the output register when the check stage advances)
//  time-base words update the time register at acceptance and give no output word
//  reset clears the window through per-entry valid bits, no clearing pass
//  a stalled output holds the check stage, which holds s_tready low

module sonar_spike_rejection_filter_unit
  import ssrf_pkg::*;
#(
  parameter int WINDOW_DEPTH = WINDOW_DEPTH_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_tvalid,
  output logic                   s_tready,
  input  logic [IN_TDATA_W-1:0]  s_tdata,   // timestamp_ms[31:0], range_mm[47:32]
  input  logic [IN_TUSER_W-1:0]  s_tuser,   // operation[0]
  output logic                   m_tvalid,
  input  logic                   m_tready,
  output logic [OUT_TDATA_W-1:0] m_tdata,   // sample_ok[0], zeros above
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]       cfg_data
);

  localparam int SLOT_W = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
  localparam int SUM_W  = RANGE_W + $clog2(WINDOW_DEPTH);
  localparam logic [SUM_W-1:0]  SUM_MAX   = SUM_W'((2 ** RANGE_W - 1) * WINDOW_DEPTH);
  localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(WINDOW_DEPTH - 1);

  logic [CFG_W-1:0]   range_min;
  logic [CFG_W-1:0]   range_max;
  logic [CFG_W-1:0]   mean_limit;
  logic [CFG_W-1:0]   speed_limit;

  logic [TIME_W-1:0]  prev_time;
  logic [RANGE_W-1:0] prev_range;

  logic               s1_valid;
  logic [RANGE_W-1:0] s1_range;
  logic [TIME_W-1:0]  s1_dt;
  logic [RANGE_W-1:0] s1_step;

  logic [SUM_W-1:0]   window_sum;
  logic [SLOT_W-1:0]  write_slot;
  logic [SLOT_W-1:0]  write_slot_next;
  logic [RANGE_W-1:0] oldest;

  logic               out_ok;

  logic               in_fire;
  logic               s1_advance;
  logic               commit;
  logic               ok;
  ssrf_verdict_t      verdict;

  logic [TIME_W-1:0]  in_time;
  logic [RANGE_W-1:0] in_range;
  op_t                in_op;

  assign in_time  = s_tdata[TIME_W-1:0];
  assign in_range = s_tdata[TIME_W +: RANGE_W];
  assign in_op    = op_t'(s_tuser);

  assign cfg_ready  = 1'b1;
  assign s1_advance = s1_valid && (!m_tvalid || m_tready);
  assign s_tready   = !s1_valid || s1_advance;
  assign in_fire    = s_tvalid && s_tready;

  assign ok     = verdict.range_pass && verdict.mean_pass && verdict.speed_pass;
  assign commit = s1_advance && ok;

  always_comb begin
    write_slot_next = write_slot;
    if (commit) begin
      write_slot_next = (write_slot == SLOT_LAST) ? '0 : write_slot + SLOT_W'(1);
    end
  end

  // config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      range_min   <= RANGE_MIN_RST;
      range_max   <= RANGE_MAX_RST;
      mean_limit  <= MEAN_LIMIT_RST;
      speed_limit <= SPEED_LIMIT_RST;
    end else if (cfg_valid) begin
      case (cfg_reg_t'(cfg_index))
        CFG_RANGE_MIN:   range_min   <= cfg_data;
        CFG_RANGE_MAX:   range_max   <= cfg_data;
        CFG_MEAN_LIMIT:  mean_limit  <= cfg_data;
        CFG_SPEED_LIMIT: speed_limit <= cfg_data;
        default: ;
      endcase
    end
  end

  // input stage: time step against the previous word, range step against the previous measurement
  always_ff @(posedge clk) begin
    if (rst) begin
      prev_time  <= '0;
      prev_range <= '0;
      s1_valid   <= 1'b0;
    end else begin
      if (s1_advance) begin
        s1_valid <= 1'b0;
      end
      if (in_fire) begin
        prev_time <= in_time;
        if (in_op == OP_MEASURE) begin
          prev_range <= in_range;
          s1_valid   <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && in_op == OP_MEASURE) begin
      s1_range <= in_range;
      s1_dt    <= in_time - prev_time;
      s1_step  <= (in_range > prev_range) ? (in_range - prev_range)
                                          : (prev_range - in_range);
    end
  end

  ssrf_check #(
    .WINDOW_DEPTH (WINDOW_DEPTH),
    .SUM_W        (SUM_W)
  ) u_check (
    .range_mm    (s1_range),
    .dt          (s1_dt),
    .range_step  (s1_step),
    .window_sum  (window_sum),
    .range_min   (range_min),
    .range_max   (range_max),
    .mean_limit  (mean_limit),
    .speed_limit (speed_limit),
    .verdict     (verdict)
  );

  // read word always tracks the slot to be overwritten next
  ssrf_window_mem #(
    .WINDOW_DEPTH (WINDOW_DEPTH),
    .SLOT_W       (SLOT_W)
  ) u_window (
    .clk     (clk),
    .rst     (rst),
    .rd_slot (write_slot_next),
    .wr_en   (commit),
    .wr_slot (write_slot),
    .wr_data (s1_range),
    .rd_data (oldest)
  );

  // running sum and slot pointer
  always_ff @(posedge clk) begin
    if (rst) begin
      window_sum <= '0;
      write_slot <= '0;
    end else begin
      write_slot <= write_slot_next;
      if (commit) begin
        window_sum <= window_sum - SUM_W'(oldest) + SUM_W'(s1_range);
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (s1_advance) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_advance) begin
      out_ok <= ok;
    end
  end

  assign m_tdata = {{(OUT_TDATA_W-1){1'b0}}, out_ok};

`ifndef SYNTHESIS
  a_sum_bound: assert property (@(posedge clk) disable iff (rst)
    window_sum <= SUM_MAX)
    else $error("window sum beyond full-scale window");

  a_slot_bound: assert property (@(posedge clk) disable iff (rst)
    write_slot <= SLOT_LAST)
    else $error("write slot outside window");

  a_out_from_check: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(s1_valid))
    else $error("output word without a measurement in the check stage");

  a_sum_steady: assert property (@(posedge clk) disable iff (rst)
    !commit |=> $stable(window_sum))
    else $error("window sum changed without an accepted sample");
`endif

endmodule

>>> rtl/ssrf_window_mem.sv
// ring window store: synchronous memory with registered read, per-entry valid bits
// depends on ssrf_pkg
`timescale 1ns / 1ps

module ssrf_window_mem
  import ssrf_pkg::*;
#(
  parameter int WINDOW_DEPTH = WINDOW_DEPTH_DEF,
  parameter int SLOT_W       = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1
) (
  input  logic               clk,
  input  logic               rst,
  input  logic [SLOT_W-1:0]  rd_slot,
  input  logic               wr_en,
  input  logic [SLOT_W-1:0]  wr_slot,
  input  logic [RANGE_W-1:0] wr_data,
  output logic [RANGE_W-1:0] rd_data
);

  logic [RANGE_W-1:0]      mem [WINDOW_DEPTH];
  logic [WINDOW_DEPTH-1:0] live;
  logic [RANGE_W-1:0]      rd_raw;
  logic                    rd_live;
  logic                    fwd;

  assign fwd = wr_en && (wr_slot == rd_slot);

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_slot] <= wr_data;
    end
    rd_raw <= fwd ? wr_data : mem[rd_slot];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      live    <= '0;
      rd_live <= 1'b0;
    end else begin
      if (wr_en) begin
        live[wr_slot] <= 1'b1;
      end
      rd_live <= fwd || live[rd_slot];
    end
  end

  // never-written entries read as zero
  assign rd_data = rd_live ? rd_raw : '0;

endmodule

>>> rtl/ssrf_check.sv
// band, window-mean and rate-of-change checks for one measurement
// depends on ssrf_pkg
`timescale 1ns / 1ps

module ssrf_check
  import ssrf_pkg::*;
#(
  parameter int WINDOW_DEPTH = WINDOW_DEPTH_DEF,
  parameter int SUM_W        = RANGE_W + $clog2(WINDOW_DEPTH)
) (
  input  logic [RANGE_W-1:0] range_mm,
  input  logic [TIME_W-1:0]  dt,
  input  logic [RANGE_W-1:0] range_step,
  input  logic [SUM_W-1:0]   window_sum,
  input  logic [CFG_W-1:0]   range_min,
  input  logic [CFG_W-1:0]   range_max,
  input  logic [CFG_W-1:0]   mean_limit,
  input  logic [CFG_W-1:0]   speed_limit,
  output ssrf_verdict_t      verdict
);

  logic [SUM_W-1:0]         range_scaled;
  logic [SUM_W-1:0]         limit_scaled;
  logic [SUM_W-1:0]         mean_dev;
  logic [SCALED_DIFF_W-1:0] step_scaled;
  logic [PRODUCT_W-1:0]     step_allowed;

  assign range_scaled = SUM_W'(range_mm) * SUM_W'(WINDOW_DEPTH);
  assign limit_scaled = SUM_W'(mean_limit) * SUM_W'(WINDOW_DEPTH);
  assign mean_dev     = (range_scaled > window_sum) ? (range_scaled - window_sum)
                                                    : (window_sum - range_scaled);
  assign step_scaled  = SCALED_DIFF_W'(range_step) * SCALED_DIFF_W'(SPEED_SCALE);
  assign step_allowed = PRODUCT_W'(speed_limit) * PRODUCT_W'(dt);

  always_comb begin
    verdict.range_pass = (range_mm > range_min) && (range_mm < range_max);
    verdict.mean_pass  = (mean_dev <= limit_scaled);
    verdict.speed_pass = (PRODUCT_W'(step_scaled) <= step_allowed);
  end

endmodule

>>> test/tb_sonar_spike_rejection_filter_unit.sv
`timescale 1ns / 1ps
// self-checking bench for sonar_spike_rejection_filter_unit: a cycle-free predictor of
// band, window-mean and rate checks scores every sample_ok verdict in order
// depends on ssrf_pkg and the filter rtl only

module tb_sonar_spike_rejection_filter_unit;
  import ssrf_pkg::*;

  localparam int DEPTH       = WINDOW_DEPTH_DEF;
  localparam int CYCLE_LIMIT = 100000;
  localparam int LONG_HOLD   = 80;
  localparam int SETTLE      = 6;

  logic                   clk;
  logic                   rst;
  logic                   s_tvalid;
  logic                   s_tready;
  logic [IN_TDATA_W-1:0]  s_tdata;   // timestamp_ms[31:0], range_mm[47:32]
  logic [IN_TUSER_W-1:0]  s_tuser;   // operation[0]
  logic                   m_tvalid;
  logic                   m_tready;
  logic [OUT_TDATA_W-1:0] m_tdata;   // sample_ok[0], zeros above
  logic                   cfg_valid;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_W-1:0]       cfg_data;

  sonar_spike_rejection_filter_unit #(
    .WINDOW_DEPTH(DEPTH)
  ) u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  // predictor copy of the filter registers and state
  logic [CFG_W-1:0]   band_lo;
  logic [CFG_W-1:0]   band_hi;
  logic [CFG_W-1:0]   mean_tol;
  logic [CFG_W-1:0]   speed_tol;
  logic [RANGE_W-1:0] window_mem [DEPTH];
  logic [63:0]        window_total;
  int                 next_slot;
  logic [RANGE_W-1:0] last_range;
  logic [TIME_W-1:0]  last_stamp;

  logic verdict_queue [$];

  int  cycle_count;
  int  mismatches;
  int  words_in;
  int  measures_in;
  int  verdicts_checked;
  int  passes_seen;
  int  stall_cycles;
  bit  sender_idles;
  bit  receiver_idles;
  int  hold_asks;
  int  hold_taken;
  int  hold_left;
  int  burst_left;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d verdicts outstanding", cycle_count,
               verdict_queue.size());
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  task automatic report_mismatch(input string what);
    $display("mismatch at cycle %0d: %s", cycle_count, what);
    mismatches++;
  endtask

  // band, window-mean and rate checks; updates the window on a pass
  function automatic logic judge_sample(input logic [TIME_W-1:0] stamp,
                                        input logic [RANGE_W-1:0] rng);
    logic [TIME_W-1:0] dt;
    logic [63:0]       scaled;
    logic [63:0]       mean_gap;
    logic [63:0]       step;
    logic              pass;
    dt       = stamp - last_stamp;
    scaled   = 64'(rng) * DEPTH;
    mean_gap = (scaled > window_total) ? scaled - window_total : window_total - scaled;
    step     = (rng > last_range) ? 64'(rng - last_range) : 64'(last_range - rng);
    pass     = (rng > band_lo) && (rng < band_hi);
    if (mean_gap > 64'(mean_tol) * DEPTH) pass = 1'b0;
    if (step * 1000 > 64'(speed_tol) * 64'(dt)) pass = 1'b0;
    if (pass) begin
      window_total          = window_total - window_mem[next_slot] + rng;
      window_mem[next_slot] = rng;
      next_slot             = (next_slot + 1) % DEPTH;
    end
    last_range = rng;
    last_stamp = stamp;
    return pass;
  endfunction

  // predictor update on accepted words and in-order verdict check
  always @(posedge clk) begin
    logic want;
    if (rst) begin
      band_lo      = RANGE_MIN_RST;
      band_hi      = RANGE_MAX_RST;
      mean_tol     = MEAN_LIMIT_RST;
      speed_tol    = SPEED_LIMIT_RST;
      for (int i = 0; i < DEPTH; i++) window_mem[i] = '0;
      window_total = '0;
      next_slot    = 0;
      last_range   = '0;
      last_stamp   = '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_reg_t'(cfg_index))
          CFG_RANGE_MIN:   band_lo   = cfg_data;
          CFG_RANGE_MAX:   band_hi   = cfg_data;
          CFG_MEAN_LIMIT:  mean_tol  = cfg_data;
          CFG_SPEED_LIMIT: speed_tol = cfg_data;
          default: ;
        endcase
      end
      if (s_tvalid && s_tready) begin
        words_in++;
        if (op_t'(s_tuser) == OP_MEASURE) begin
          measures_in++;
          verdict_queue.push_back(judge_sample(s_tdata[TIME_W-1:0],
                                               s_tdata[TIME_W+RANGE_W-1:TIME_W]));
        end else begin
          last_stamp = s_tdata[TIME_W-1:0];
        end
      end
      if (s_tvalid && !s_tready) stall_cycles++;
      if (m_tvalid && m_tready) begin
        if (verdict_queue.size() == 0) begin
          report_mismatch($sformatf("verdict %0b with none expected", m_tdata[0]));
        end else begin
          want = verdict_queue.pop_front();
          verdicts_checked++;
          if (m_tdata[0]) passes_seen++;
          if (m_tdata[0] !== want)
            report_mismatch($sformatf("sample_ok %0b, expected %0b", m_tdata[0], want));
        end
      end
    end
  end

  // output side: random short stalls plus an on-demand long hold
  initial begin
    m_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_asks != hold_taken) begin
        hold_taken = hold_asks;
        hold_left  = LONG_HOLD;
      end
      if (hold_left > 0) begin
        m_tready <= 1'b0;
        hold_left--;
      end else if (burst_left > 0) begin
        m_tready <= 1'b0;
        burst_left--;
      end else if (receiver_idles && $urandom_range(0, 4) == 0) begin
        m_tready   <= 1'b0;
        burst_left = $urandom_range(1, 4) - 1;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  task automatic send_word(input op_t op, input logic [TIME_W-1:0] stamp,
                           input logic [RANGE_W-1:0] rng);
    if (sender_idles && $urandom_range(0, 3) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {rng, stamp};
    s_tuser  <= op;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  task automatic wait_idle();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (verdict_queue.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic put_reg(input cfg_reg_t which, input logic [CFG_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= which;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  task automatic program_filter(input logic [CFG_W-1:0] lo, input logic [CFG_W-1:0] hi,
                                input logic [CFG_W-1:0] mtol, input logic [CFG_W-1:0] stol);
    wait_idle();
    put_reg(CFG_RANGE_MIN, lo);
    put_reg(CFG_RANGE_MAX, hi);
    put_reg(CFG_MEAN_LIMIT, mtol);
    put_reg(CFG_SPEED_LIMIT, stol);
    cfg_valid <= 1'b0;
  endtask

  task automatic test_reset_defaults();
    send_word(OP_MEASURE, 32'd0, 16'd0);              // zero step, no change
    send_word(OP_MEASURE, 32'd0, 16'd350);            // zero step with a change
    send_word(OP_TIME_BASE, 32'd1000, 16'hFFFF);
    send_word(OP_MEASURE, 32'd2000, 16'd350);
    send_word(OP_MEASURE, 32'd2100, 16'd302);
    send_word(OP_MEASURE, 32'd2200, 16'd301);         // on the lower band edge
    send_word(OP_MEASURE, 32'd2300, 16'd2599);
    send_word(OP_MEASURE, 32'd2400, 16'd2600);        // on the upper band edge
    send_word(OP_MEASURE, 32'd2500, 16'hFFFF);
    send_word(OP_TIME_BASE, 32'hFFFF_FFF0, 16'd0);
    send_word(OP_MEASURE, 32'h0000_0050, 16'd360);    // step across the time wrap
    send_word(OP_MEASURE, 32'h0000_00B0, 16'd370);
    send_word(OP_MEASURE, 32'hFFFF_FFFF, 16'd370);
    // enough passes to wrap the window slot
    for (int k = 0; k < 10; k++)
      send_word(OP_MEASURE, 32'(999 + 100 * k), 16'(330 + 7 * k));
  endtask

  task automatic test_band_edges();
    program_filter(16'd1000, 16'd1001, 16'hFFFF, 16'hFFFF);
    send_word(OP_MEASURE, 32'd100000, 16'd1000);
    send_word(OP_MEASURE, 32'd101000, 16'd1001);
    program_filter(16'd2000, 16'd1500, 16'hFFFF, 16'hFFFF);
    send_word(OP_MEASURE, 32'd102000, 16'd1800);
    program_filter(16'd500, 16'd2600, 16'hFFFF, 16'hFFFF);
    send_word(OP_MEASURE, 32'd103000, 16'd500);
    send_word(OP_MEASURE, 32'd104000, 16'd501);
    send_word(OP_MEASURE, 32'd105000, 16'd2599);
    send_word(OP_MEASURE, 32'd106000, 16'd2600);
  endtask

  task automatic test_register_extremes();
    program_filter(16'd0, 16'd0, 16'd0, 16'd0);
    send_word(OP_MEASURE, 32'd106000, 16'd2600);
    send_word(OP_MEASURE, 32'd200000, 16'd0);
    program_filter(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    send_word(OP_MEASURE, 32'd300000, 16'hFFFF);
    program_filter(16'd0, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    send_word(OP_MEASURE, 32'd400000, 16'd1);
    send_word(OP_MEASURE, 32'd500000, 16'hFFFE);
  endtask

  task automatic test_output_stall();
    logic [TIME_W-1:0] stamp;
    stamp = 32'h4000_0000;
    program_filter(16'd100, 16'd60000, 16'hFFFF, 16'hFFFF);
    sender_idles = 1'b0;
    hold_asks++;
    for (int k = 0; k < 24; k++) begin
      stamp = stamp + 20;
      send_word(OP_MEASURE, stamp, 16'(1000 + 3 * k));
    end
    sender_idles = 1'b1;
  endtask

  // a drifting target with jitter, plus spikes, stray words and time-base updates
  task automatic random_track(input int count, input int centre, input int step_max,
                              input logic [TIME_W-1:0] start_stamp);
    logic [TIME_W-1:0] stamp;
    int                rng;
    int                kind;
    stamp = start_stamp;
    rng   = centre;
    send_word(OP_TIME_BASE, stamp, 16'($urandom));
    for (int k = 0; k < count; k++) begin
      kind = $urandom_range(0, 99);
      if (kind < 8) begin
        if ($urandom_range(0, 1) == 1) stamp = $urandom;
        else stamp = stamp + $urandom_range(0, 500);
        send_word(OP_TIME_BASE, stamp, 16'($urandom));
      end else if (kind < 18) begin
        if ($urandom_range(0, 1) == 1) stamp = $urandom;
        else stamp = stamp + $urandom_range(0, 50);
        send_word(OP_MEASURE, stamp, 16'($urandom));
      end else if (kind < 25) begin
        stamp = stamp + $urandom_range(1, 200);
        send_word(OP_MEASURE, stamp,
                  16'(rng + int'($urandom_range(step_max * 4, step_max * 40))));
      end else begin
        stamp = stamp + $urandom_range(0, 200);
        rng   = rng + int'($urandom_range(0, 2 * step_max)) - step_max;
        if (rng < 0) rng = 0;
        if (rng > 65535) rng = 65535;
        send_word(OP_MEASURE, stamp, 16'(rng));
      end
    end
  endtask

  task automatic test_random_tracks();
    int centre;
    program_filter(RANGE_MIN_RST, RANGE_MAX_RST, MEAN_LIMIT_RST, SPEED_LIMIT_RST);
    random_track(70, 400, 15, 32'h0010_0000);
    program_filter(16'd100, 16'd60000, 16'hFFFF, 16'hFFFF);
    random_track(80, 20000, 500, 32'hFFFF_F000);
    program_filter(16'd15000, 16'd25000, 16'd1500, 16'd20000);
    centre = int'(window_total / DEPTH);
    random_track(70, centre, 100, $urandom);
    centre = int'(window_total / DEPTH);
    program_filter(16'(centre - 1000), 16'(centre + 1000), 16'd200, 16'd1000);
    random_track(60, centre, 20, $urandom);
  endtask

  task automatic test_quiet_tail();
    int centre;
    program_filter(16'd100, 16'd60000, 16'd3000, 16'd30000);
    sender_idles   = 1'b0;
    receiver_idles = 1'b0;
    centre         = int'(window_total / DEPTH);
    random_track(60, centre, 50, $urandom);
  endtask

  initial begin
    sender_idles   = 1'b1;
    receiver_idles = 1'b1;
    rst       <= 1'b1;
    s_tvalid  <= 1'b0;
    s_tdata   <= '0;
    s_tuser   <= OP_TIME_BASE;
    cfg_valid <= 1'b0;
    cfg_index <= CFG_RANGE_MIN;
    cfg_data  <= '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_defaults();
    test_band_edges();
    test_register_extremes();
    test_output_stall();
    test_random_tracks();
    test_quiet_tail();
    wait_idle();
    $display("run covered %0d input words (%0d measurements) over several register sets",
             words_in, measures_in);
    $display("%0d verdicts checked, %0d passed, %0d cycles of input held off",
             verdicts_checked, passes_seen, stall_cycles);
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
